// ===== rtl/c8vm_pkg.sv =====
// ----------------------------------------------------------------------------
// c8vm_pkg
// Shared types, constants and tables of the bytecode interpreter core.
// ----------------------------------------------------------------------------
package c8vm_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW = 12;
  localparam int FONT_BASE = 80;
  localparam int FONT_LEN = 80;
  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;
  localparam int ROW_AW = 5;
  localparam int NUM_REGS = 16;
  localparam int REG_AW = 4;
  localparam logic [15:0] PC_RESET = 16'h0200;
  localparam logic [15:0] PC_LIMIT = 16'd4095;

  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_EXEC = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;
  localparam logic [1:0] FN_ROW = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MEM = 2'd1;
  localparam logic [1:0] ST_STACK = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  localparam logic [3:0] OP_SYS = 4'h0;
  localparam logic [3:0] OP_JP = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE = 4'h3;
  localparam logic [3:0] OP_SNE = 4'h4;
  localparam logic [3:0] OP_SER = 4'h5;
  localparam logic [3:0] OP_LD = 4'h6;
  localparam logic [3:0] OP_ADD = 4'h7;
  localparam logic [3:0] OP_ALU = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND = 4'hC;
  localparam logic [3:0] OP_DRW = 4'hD;
  localparam logic [3:0] OP_SKP = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [11:0] SYS_CLS = 12'h0E0;
  localparam logic [11:0] SYS_RET = 12'h0EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP = 8'hA1;

  localparam logic [7:0] F_GET_DT = 8'h07;
  localparam logic [7:0] F_WAIT_KEY = 8'h0A;
  localparam logic [7:0] F_SET_DT = 8'h15;
  localparam logic [7:0] F_SET_ST = 8'h18;
  localparam logic [7:0] F_ADD_I = 8'h1E;
  localparam logic [7:0] F_GLYPH = 8'h29;
  localparam logic [7:0] F_BCD = 8'h33;
  localparam logic [7:0] F_STORE = 8'h55;
  localparam logic [7:0] F_LOAD = 8'h65;

  localparam logic [7:0] GLYPHS [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ROW, S_FETCH_HI, S_FETCH_LO, S_READ_X, S_READ_Y,
    S_EXEC, S_POP, S_WRITE_VF, S_DRAW_RD, S_DRAW_WR, S_BCD,
    S_STORE_RD, S_STORE_WR, S_LOAD_RD, S_LOAD_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] value;
    logic flag;
    logic set_vf;
    logic illegal;
  } alu_res_t;

endpackage

// ===== rtl/bytecode_vm_cpu_core.sv =====
// ----------------------------------------------------------------------------
// bytecode_vm_cpu_core
// Interpreter core whose memory, registers, stack and screen live in RAMs.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load or timer item needs no RAM read, a row
// read reads the screen RAM, and an instruction is fetched, has its registers
// read and is executed, a sprite draw then walking its rows, BCD its digits and
// a register block copy its registers. After reset a pass over main memory
// writes the font and clears the rest; no item is taken until it ends.
module bytecode_vm_cpu_core import c8vm_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_key_mask,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_program_counter,
  output logic [63:0] out_row_pixels,
  output logic        out_sound_on,
  output logic        out_waiting_key
);

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [MEM_AW-1:0] clr_r, clr_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [7:0] rnd_r, rnd_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [7:0] delay_r, delay_nxt;
  logic [7:0] sound_r, sound_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0] vx_r, vx_nxt;
  logic [7:0] vy_r, vy_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic hit_r, hit_nxt;
  logic [7:0] vf_val_r, vf_val_nxt;
  logic [1:0] status_r, status_nxt;
  logic [63:0] pix_r, pix_nxt;
  logic wait_r, wait_nxt;
  logic [SCREEN_H-1:0] scr_valid_r, scr_valid_nxt;
  logic [NUM_REGS-1:0] reg_valid_r;
  logic [REG_AW-1:0] reg_ra_r;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic [15:0] out_pc_r;
  logic [63:0] out_pix_r;
  logic out_sound_r, out_wait_r;
  logic out_load;

  logic mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;
  logic reg_we, reg_re;
  logic [REG_AW-1:0] reg_waddr, reg_raddr;
  logic [7:0] reg_wdata, reg_rdata;
  logic scr_we, scr_re;
  logic [ROW_AW-1:0] scr_waddr, scr_raddr;
  logic [63:0] scr_wdata, scr_rdata;
  logic stk_we, stk_re;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [15:0] stk_wdata, stk_rdata;

  logic [11:0] nnn;
  logic [3:0] opx, opy, opn;
  logic [7:0] kk;
  logic [15:0] pc2, pc4;
  logic [7:0] rv;
  alu_res_t alu_res;
  logic [3:0] key_enc;
  logic [12:0] clr_off;
  logic [ROW_AW-1:0] draw_row;
  logic [127:0] rot_wide;
  logic [63:0] spr_mask, old_row;
  logic [1:0] bcd_h;
  logic [7:0] bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0] bcd_t;
  logic [7:0] bcd_o;
  logic [7:0] bcd_digit;
  logic [11:0] win_addr;

  c8vm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8vm_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_reg_mem (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .re(reg_re), .raddr(reg_raddr), .rdata(reg_rdata)
  );

  c8vm_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_screen_mem (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .re(scr_re), .raddr(scr_raddr), .rdata(scr_rdata)
  );

  c8vm_ram #(.WIDTH(16), .DEPTH(2 ** SAW)) u_stack_mem (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  c8vm_alu u_alu (
    .op(op_r[3:0]), .a(vx_r), .b(vy_r), .res(alu_res)
  );

  assign nnn = op_r[11:0];
  assign opx = op_r[11:8];
  assign opy = op_r[7:4];
  assign opn = op_r[3:0];
  assign kk = op_r[7:0];
  assign pc2 = pc_r + 16'd2;
  assign pc4 = pc_r + 16'd4;
  assign rv = reg_valid_r[reg_ra_r] ? reg_rdata : 8'd0;
  assign clr_off = {1'b0, clr_r} - 13'(FONT_BASE);
  assign win_addr = idx_r[11:0] + {8'd0, cnt_r};
  assign draw_row = vy_r[ROW_AW-1:0] + {1'b0, cnt_r};
  assign rot_wide = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> vx_r[5:0];
  assign spr_mask = rot_wide[63:0];
  assign old_row = scr_valid_r[draw_row] ? scr_rdata : 64'd0;

  assign bcd_h = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
  assign bcd_rem = vx_r - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
  assign bcd_prod = 15'(bcd_rem[6:0]) * 15'd205;
  assign bcd_t = bcd_prod[14:11];
  assign bcd_o = bcd_rem - ({4'd0, bcd_t} * 8'd10);

  always_comb begin
    case (cnt_r[1:0])
      2'd0: bcd_digit = {6'd0, bcd_h};
      2'd1: bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = bcd_o;
    endcase
  end

  always_comb begin
    key_enc = '0;
    for (int i = 0; i < 16; i++) begin
      if (keys_r[i]) begin
        key_enc = 4'(i);
      end
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    addr_nxt = addr_r;
    keys_nxt = keys_r;
    rnd_nxt = rnd_r;
    pc_nxt = pc_r;
    idx_nxt = idx_r;
    level_nxt = level_r;
    delay_nxt = delay_r;
    sound_nxt = sound_r;
    op_nxt = op_r;
    vx_nxt = vx_r;
    vy_nxt = vy_r;
    cnt_nxt = cnt_r;
    hit_nxt = hit_r;
    vf_val_nxt = vf_val_r;
    status_nxt = status_r;
    pix_nxt = pix_r;
    wait_nxt = wait_r;
    scr_valid_nxt = scr_valid_r;
    in_stall = 1'b1;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = '0;
    reg_we = 1'b0;
    reg_waddr = '0;
    reg_wdata = '0;
    reg_re = 1'b0;
    reg_raddr = '0;
    scr_we = 1'b0;
    scr_waddr = '0;
    scr_wdata = '0;
    scr_re = 1'b0;
    scr_raddr = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re = 1'b0;
    stk_raddr = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r;
        if (clr_off < 13'(FONT_LEN)) begin
          mem_wdata = GLYPHS[clr_off[6:0]];
        end
        clr_nxt = clr_r + MEM_AW'(1);
        if (clr_r == MEM_AW'(MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          addr_nxt = in_address;
          keys_nxt = in_key_mask;
          rnd_nxt = in_random_byte;
          status_nxt = ST_OK;
          pix_nxt = '0;
          wait_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_func)
            FN_LOAD: begin
              mem_we = 1'b1;
              mem_waddr = in_address;
              mem_wdata = in_data;
            end
            FN_TICK: begin
              delay_nxt = delay_r - {7'd0, (delay_r != 8'd0)};
              sound_nxt = sound_r - {7'd0, (sound_r != 8'd0)};
            end
            FN_ROW: begin
              if (in_address < 12'(SCREEN_H)) begin
                scr_re = 1'b1;
                scr_raddr = in_address[ROW_AW-1:0];
                state_nxt = S_ROW;
              end else begin
                status_nxt = ST_MEM;
              end
            end
            default: begin
              if (pc_r >= PC_LIMIT) begin
                status_nxt = ST_MEM;
              end else begin
                mem_re = 1'b1;
                mem_raddr = pc_r[MEM_AW-1:0];
                state_nxt = S_FETCH_HI;
              end
            end
          endcase
        end
      end
      S_ROW: begin
        pix_nxt = scr_valid_r[addr_r[ROW_AW-1:0]] ? scr_rdata : 64'd0;
        state_nxt = S_DONE;
      end
      S_FETCH_HI: begin
        op_nxt[15:8] = mem_rdata;
        mem_re = 1'b1;
        mem_raddr = pc_r[MEM_AW-1:0] + MEM_AW'(1);
        state_nxt = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        op_nxt[7:0] = mem_rdata;
        reg_re = 1'b1;
        reg_raddr = opx;
        state_nxt = S_READ_X;
      end
      S_READ_X: begin
        vx_nxt = rv;
        reg_re = 1'b1;
        reg_raddr = (op_r[15:12] == OP_JPV0) ? 4'd0 : opy;
        state_nxt = S_READ_Y;
      end
      S_READ_Y: begin
        vy_nxt = rv;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r[15:12])
          OP_SYS: begin
            if (nnn == SYS_CLS) begin
              scr_valid_nxt = '0;
              pc_nxt = pc2;
            end else if (nnn == SYS_RET) begin
              if (level_r == '0) begin
                status_nxt = ST_STACK;
              end else begin
                stk_re = 1'b1;
                stk_raddr = SAW'(level_r - LW'(1));
                state_nxt = S_POP;
              end
            end else begin
              status_nxt = ST_ILLEGAL;
            end
          end
          OP_JP: pc_nxt = {4'd0, nnn};
          OP_CALL: begin
            if (level_r >= LW'(STACK_DEPTH)) begin
              status_nxt = ST_STACK;
            end else begin
              stk_we = 1'b1;
              stk_waddr = SAW'(level_r);
              stk_wdata = pc2;
              level_nxt = level_r + LW'(1);
              pc_nxt = {4'd0, nnn};
            end
          end
          OP_SE: pc_nxt = (vx_r == kk) ? pc4 : pc2;
          OP_SNE: pc_nxt = (vx_r != kk) ? pc4 : pc2;
          OP_SER: begin
            if (opn != 4'd0) begin
              status_nxt = ST_ILLEGAL;
            end else begin
              pc_nxt = (vx_r == vy_r) ? pc4 : pc2;
            end
          end
          OP_LD: begin
            reg_we = 1'b1;
            reg_waddr = opx;
            reg_wdata = kk;
            pc_nxt = pc2;
          end
          OP_ADD: begin
            reg_we = 1'b1;
            reg_waddr = opx;
            reg_wdata = vx_r + kk;
            pc_nxt = pc2;
          end
          OP_ALU: begin
            if (alu_res.illegal) begin
              status_nxt = ST_ILLEGAL;
            end else begin
              reg_we = 1'b1;
              reg_waddr = opx;
              reg_wdata = alu_res.value;
              pc_nxt = pc2;
              if (alu_res.set_vf) begin
                vf_val_nxt = {7'd0, alu_res.flag};
                state_nxt = S_WRITE_VF;
              end
            end
          end
          OP_SNER: begin
            if (opn != 4'd0) begin
              status_nxt = ST_ILLEGAL;
            end else begin
              pc_nxt = (vx_r != vy_r) ? pc4 : pc2;
            end
          end
          OP_LDI: begin
            idx_nxt = {4'd0, nnn};
            pc_nxt = pc2;
          end
          OP_JPV0: pc_nxt = {4'd0, nnn} + {8'd0, vy_r};
          OP_RND: begin
            reg_we = 1'b1;
            reg_waddr = opx;
            reg_wdata = rnd_r & kk;
            pc_nxt = pc2;
          end
          OP_DRW: begin
            if (({1'b0, idx_r} + {13'd0, opn}) > 17'(MEM_BYTES)) begin
              status_nxt = ST_MEM;
            end else if (opn == 4'd0) begin
              vf_val_nxt = '0;
              pc_nxt = pc2;
              state_nxt = S_WRITE_VF;
            end else begin
              cnt_nxt = '0;
              hit_nxt = 1'b0;
              state_nxt = S_DRAW_RD;
            end
          end
          OP_SKP: begin
            if ((kk != KEY_DOWN && kk != KEY_UP) || vx_r > 8'd15) begin
              status_nxt = ST_ILLEGAL;
            end else if (keys_r[vx_r[3:0]] == (kk == KEY_DOWN)) begin
              pc_nxt = pc4;
            end else begin
              pc_nxt = pc2;
            end
          end
          default: begin
            case (kk)
              F_GET_DT: begin
                reg_we = 1'b1;
                reg_waddr = opx;
                reg_wdata = delay_r;
                pc_nxt = pc2;
              end
              F_WAIT_KEY: begin
                if (keys_r == '0) begin
                  wait_nxt = 1'b1;
                end else begin
                  reg_we = 1'b1;
                  reg_waddr = opx;
                  reg_wdata = {4'd0, key_enc};
                  pc_nxt = pc2;
                end
              end
              F_SET_DT: begin
                delay_nxt = vx_r;
                pc_nxt = pc2;
              end
              F_SET_ST: begin
                sound_nxt = vx_r;
                pc_nxt = pc2;
              end
              F_ADD_I: begin
                idx_nxt = idx_r + {8'd0, vx_r};
                pc_nxt = pc2;
              end
              F_GLYPH: begin
                if (vx_r > 8'd15) begin
                  status_nxt = ST_ILLEGAL;
                end else begin
                  idx_nxt = 16'(FONT_BASE) + {10'd0, vx_r[3:0], 2'd0}
                            + {12'd0, vx_r[3:0]};
                  pc_nxt = pc2;
                end
              end
              F_BCD: begin
                if (({1'b0, idx_r} + 17'd2) > 17'(PC_LIMIT)) begin
                  status_nxt = ST_MEM;
                end else begin
                  cnt_nxt = '0;
                  state_nxt = S_BCD;
                end
              end
              F_STORE, F_LOAD: begin
                if (({1'b0, idx_r} + {13'd0, opx}) > 17'(PC_LIMIT)) begin
                  status_nxt = ST_MEM;
                end else begin
                  cnt_nxt = '0;
                  state_nxt = (kk == F_STORE) ? S_STORE_RD : S_LOAD_RD;
                end
              end
              default: status_nxt = ST_ILLEGAL;
            endcase
          end
        endcase
      end
      S_POP: begin
        pc_nxt = stk_rdata;
        level_nxt = level_r - LW'(1);
        state_nxt = S_DONE;
      end
      S_WRITE_VF: begin
        reg_we = 1'b1;
        reg_waddr = 4'hF;
        reg_wdata = vf_val_r;
        state_nxt = S_DONE;
      end
      S_DRAW_RD: begin
        mem_re = 1'b1;
        mem_raddr = win_addr;
        scr_re = 1'b1;
        scr_raddr = draw_row;
        state_nxt = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        hit_nxt = hit_r | (|(old_row & spr_mask));
        scr_we = 1'b1;
        scr_waddr = draw_row;
        scr_wdata = old_row ^ spr_mask;
        scr_valid_nxt[draw_row] = 1'b1;
        if (cnt_r == opn - 4'd1) begin
          vf_val_nxt = {7'd0, hit_nxt};
          pc_nxt = pc2;
          state_nxt = S_WRITE_VF;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
          state_nxt = S_DRAW_RD;
        end
      end
      S_BCD: begin
        mem_we = 1'b1;
        mem_waddr = win_addr;
        mem_wdata = bcd_digit;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) begin
          pc_nxt = pc2;
          state_nxt = S_DONE;
        end
      end
      S_STORE_RD: begin
        reg_re = 1'b1;
        reg_raddr = cnt_r;
        state_nxt = S_STORE_WR;
      end
      S_STORE_WR: begin
        mem_we = 1'b1;
        mem_waddr = win_addr;
        mem_wdata = rv;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = S_STORE_RD;
        if (cnt_r == opx) begin
          pc_nxt = pc2;
          state_nxt = S_DONE;
        end
      end
      S_LOAD_RD: begin
        mem_re = 1'b1;
        mem_raddr = win_addr;
        state_nxt = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        reg_we = 1'b1;
        reg_waddr = cnt_r;
        reg_wdata = mem_rdata;
        cnt_nxt = cnt_r + 4'd1;
        state_nxt = S_LOAD_RD;
        if (cnt_r == opx) begin
          pc_nxt = pc2;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      pc_r <= PC_RESET;
      idx_r <= '0;
      level_r <= '0;
      delay_r <= '0;
      sound_r <= '0;
      scr_valid_r <= '0;
      reg_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      pc_r <= pc_nxt;
      idx_r <= idx_nxt;
      level_r <= level_nxt;
      delay_r <= delay_nxt;
      sound_r <= sound_nxt;
      scr_valid_r <= scr_valid_nxt;
      if (reg_we) begin
        reg_valid_r[reg_waddr] <= 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    keys_r <= keys_nxt;
    rnd_r <= rnd_nxt;
    op_r <= op_nxt;
    vx_r <= vx_nxt;
    vy_r <= vy_nxt;
    cnt_r <= cnt_nxt;
    hit_r <= hit_nxt;
    vf_val_r <= vf_val_nxt;
    status_r <= status_nxt;
    pix_r <= pix_nxt;
    wait_r <= wait_nxt;
    if (reg_re) begin
      reg_ra_r <= reg_raddr;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_pc_r <= pc_r;
      out_pix_r <= pix_r;
      out_sound_r <= (sound_r != 8'd0);
      out_wait_r <= wait_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_program_counter = out_pc_r;
  assign out_row_pixels = out_pix_r;
  assign out_sound_on = out_sound_r;
  assign out_waiting_key = out_wait_r;

endmodule

// ===== rtl/c8vm_ram.sv =====
// ----------------------------------------------------------------------------
// c8vm_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module c8vm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/c8vm_alu.sv =====
// ----------------------------------------------------------------------------
// c8vm_alu
// Register-to-register arithmetic and logic of the 8xyn instruction group.
// ----------------------------------------------------------------------------
module c8vm_alu import c8vm_pkg::*; (
  input  logic [3:0] op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output alu_res_t   res
);

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    res = '0;
    case (op)
      ALU_MOV: res.value = b;
      ALU_OR: res.value = a | b;
      ALU_AND: res.value = a & b;
      ALU_XOR: res.value = a ^ b;
      ALU_ADD: begin
        res.value = sum[7:0];
        res.flag = sum[8];
        res.set_vf = 1'b1;
      end
      ALU_SUB: begin
        res.value = a - b;
        res.flag = (a >= b);
        res.set_vf = 1'b1;
      end
      ALU_SHR: begin
        res.value = {1'b0, a[7:1]};
        res.flag = a[0];
        res.set_vf = 1'b1;
      end
      ALU_SUBN: begin
        res.value = b - a;
        res.flag = !(a > b);
        res.set_vf = 1'b1;
      end
      ALU_SHL: begin
        res.value = {a[6:0], 1'b0};
        res.flag = a[7];
        res.set_vf = 1'b1;
      end
      default: res.illegal = 1'b1;
    endcase
  end

endmodule

// ===== rtl/c8vm_checker.sv =====
// ----------------------------------------------------------------------------
// c8vm_props
// Port-level checks of the interpreter core, bound into the core module.
// ----------------------------------------------------------------------------
module c8vm_props import c8vm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [63:0] out_row_pixels,
  input logic        out_waiting_key
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Second item taken before the first finished.");

  a_pix_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_pixels != 64'd0) |-> out_status == ST_OK)
    else $error("Pixels shown with an error status.");

  a_wait_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_waiting_key |-> out_status == ST_OK && out_row_pixels == 64'd0)
    else $error("Key wait reported with an error or pixels.");

endmodule

bind bytecode_vm_cpu_core c8vm_props u_c8vm_props (.*);

// ===== bench/c8vm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8vm_checker
// Watches both channels of the interpreter core, runs its own copy of the
// machine on every accepted item and compares each result field by field.
// ----------------------------------------------------------------------------
module c8vm_checker import c8vm_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_key_mask,
  input  logic [7:0]  in_random_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_program_counter,
  input  logic [63:0] out_row_pixels,
  input  logic        out_sound_on,
  input  logic        out_waiting_key,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc;
    logic [63:0] pixels;
    logic        sound;
    logic        waiting;
  } vm_result_t;

  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] screen [SCREEN_H];
  logic [7:0]  v [NUM_REGS];
  logic [15:0] ret_stack [STACK_DEPTH];
  int          sp;
  logic [15:0] ireg, pc;
  logic [7:0]  delay_t, sound_t;
  logic        key_wait;
  vm_result_t  expected_q [$];

  function automatic logic [1:0] run_alu(logic [3:0] x, logic [3:0] y, logic [3:0] op);
    logic [8:0] a, b;
    a = {1'b0, v[x]};
    b = {1'b0, v[y]};
    case (op)
      ALU_MOV: v[x] = b[7:0];
      ALU_OR: v[x] = a[7:0] | b[7:0];
      ALU_AND: v[x] = a[7:0] & b[7:0];
      ALU_XOR: v[x] = a[7:0] ^ b[7:0];
      ALU_ADD: begin v[x] = a[7:0] + b[7:0]; v[15] = ((a + b) > 255) ? 8'd1 : 8'd0; end
      ALU_SUB: begin v[x] = a[7:0] - b[7:0]; v[15] = (a >= b) ? 8'd1 : 8'd0; end
      ALU_SHR: begin v[x] = a[7:0] >> 1; v[15] = {7'd0, a[0]}; end
      ALU_SUBN: begin v[x] = b[7:0] - a[7:0]; v[15] = (a > b) ? 8'd0 : 8'd1; end
      ALU_SHL: begin v[x] = a[7:0] << 1; v[15] = {7'd0, a[7]}; end
      default: return ST_ILLEGAL;
    endcase
    pc = pc + 16'd2;
    return ST_OK;
  endfunction

  function automatic logic [1:0] run_draw(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    logic [63:0] spr, msk;
    int col, row, r;
    logic hit;
    hit = 1'b0;
    if (int'(ireg) + int'(n) > MEM_BYTES) return ST_MEM;
    col = v[x] % SCREEN_W;
    row = v[y];
    for (int i = 0; i < n; i++) begin
      spr = {mem[(int'(ireg) + i) % MEM_BYTES], 56'd0};
      msk = (col == 0) ? spr : ((spr >> col) | (spr << (64 - col)));
      r = (row + i) % SCREEN_H;
      if ((screen[r] & msk) != 0) hit = 1'b1;
      screen[r] ^= msk;
    end
    v[15] = {7'd0, hit};
    pc = pc + 16'd2;
    return ST_OK;
  endfunction

  function automatic logic [1:0] run_misc(logic [3:0] x, logic [7:0] sub, logic [15:0] keys);
    logic [7:0] vx;
    int found;
    vx = v[x];
    case (sub)
      F_GET_DT: v[x] = delay_t;
      F_WAIT_KEY: begin
        found = -1;
        for (int i = 0; i < 16; i++) if (keys[i]) found = i;
        if (found < 0) begin
          key_wait = 1'b1;
          return ST_OK;
        end
        v[x] = found[7:0];
      end
      F_SET_DT: delay_t = vx;
      F_SET_ST: sound_t = vx;
      F_ADD_I: ireg = ireg + {8'd0, vx};
      F_GLYPH: begin
        if (vx > 15) return ST_ILLEGAL;
        ireg = 16'(FONT_BASE + vx * 5);
      end
      F_BCD: begin
        if (int'(ireg) + 2 > 4095) return ST_MEM;
        mem[ireg] = vx / 100;
        mem[ireg + 1] = (vx % 100) / 10;
        mem[ireg + 2] = vx % 10;
      end
      F_STORE, F_LOAD: begin
        if (int'(ireg) + int'(x) > 4095) return ST_MEM;
        for (int i = 0; i <= x; i++) begin
          if (sub == F_STORE) mem[int'(ireg) + i] = v[i];
          else v[i] = mem[int'(ireg) + i];
        end
      end
      default: return ST_ILLEGAL;
    endcase
    pc = pc + 16'd2;
    return ST_OK;
  endfunction

  function automatic logic [1:0] run_instruction(logic [15:0] keys, logic [7:0] rnd);
    logic [15:0] op;
    logic [11:0] nnn;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx;
    if (pc >= MEM_BYTES - 1) return ST_MEM;
    op = {mem[pc], mem[pc + 1]};
    nnn = op[11:0];
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    vx = v[x];
    case (op[15:12])
      OP_SYS: begin
        if (nnn == SYS_CLS) begin
          for (int r = 0; r < SCREEN_H; r++) screen[r] = '0;
          pc = pc + 16'd2;
        end else if (nnn == SYS_RET) begin
          if (sp == 0) return ST_STACK;
          sp--;
          pc = ret_stack[sp];
        end else return ST_ILLEGAL;
        return ST_OK;
      end
      OP_JP: begin pc = {4'd0, nnn}; return ST_OK; end
      OP_CALL: begin
        if (sp >= STACK_DEPTH) return ST_STACK;
        ret_stack[sp] = pc + 16'd2;
        sp++;
        pc = {4'd0, nnn};
        return ST_OK;
      end
      OP_SE: begin pc = pc + ((vx == kk) ? 16'd4 : 16'd2); return ST_OK; end
      OP_SNE: begin pc = pc + ((vx != kk) ? 16'd4 : 16'd2); return ST_OK; end
      OP_SER: begin
        if (n != 0) return ST_ILLEGAL;
        pc = pc + ((vx == v[y]) ? 16'd4 : 16'd2);
        return ST_OK;
      end
      OP_LD: begin v[x] = kk; pc = pc + 16'd2; return ST_OK; end
      OP_ADD: begin v[x] = vx + kk; pc = pc + 16'd2; return ST_OK; end
      OP_ALU: return run_alu(x, y, n);
      OP_SNER: begin
        if (n != 0) return ST_ILLEGAL;
        pc = pc + ((vx != v[y]) ? 16'd4 : 16'd2);
        return ST_OK;
      end
      OP_LDI: begin ireg = {4'd0, nnn}; pc = pc + 16'd2; return ST_OK; end
      OP_JPV0: begin pc = {4'd0, nnn} + {8'd0, v[0]}; return ST_OK; end
      OP_RND: begin v[x] = rnd & kk; pc = pc + 16'd2; return ST_OK; end
      OP_DRW: return run_draw(x, y, n);
      OP_SKP: begin
        if (kk != KEY_DOWN && kk != KEY_UP) return ST_ILLEGAL;
        if (vx > 15) return ST_ILLEGAL;
        if (kk == KEY_DOWN) pc = pc + (keys[vx[3:0]] ? 16'd4 : 16'd2);
        else pc = pc + (keys[vx[3:0]] ? 16'd2 : 16'd4);
        return ST_OK;
      end
      default: return run_misc(x, kk, keys);
    endcase
  endfunction

  function automatic vm_result_t step_machine(logic [1:0] fn, logic [11:0] addr,
      logic [7:0] dat, logic [15:0] keys, logic [7:0] rnd);
    vm_result_t res;
    res = '0;
    key_wait = 1'b0;
    case (fn)
      FN_LOAD: mem[addr] = dat;
      FN_EXEC: res.status = run_instruction(keys, rnd);
      FN_TICK: begin
        if (delay_t > 0) delay_t--;
        if (sound_t > 0) sound_t--;
      end
      default: begin
        if (addr < SCREEN_H) res.pixels = screen[addr];
        else res.status = ST_MEM;
      end
    endcase
    res.pc = pc;
    res.sound = (sound_t != 0);
    res.waiting = key_wait;
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    vm_result_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
      for (int i = 0; i < FONT_LEN; i++) mem[FONT_BASE + i] = GLYPHS[i];
      for (int i = 0; i < SCREEN_H; i++) screen[i] = '0;
      for (int i = 0; i < NUM_REGS; i++) v[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
      sp = 0;
      ireg = '0;
      pc = PC_RESET;
      delay_t = '0;
      sound_t = '0;
      key_wait = 1'b0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_status !== exp_res.status || out_program_counter !== exp_res.pc ||
              out_row_pixels !== exp_res.pixels || out_sound_on !== exp_res.sound ||
              out_waiting_key !== exp_res.waiting) begin
            fail_count <= fail_count + 1;
            if (out_status !== exp_res.status)
              $error("status: expected %0d, actual %0d", exp_res.status, out_status);
            if (out_program_counter !== exp_res.pc)
              $error("program_counter: expected %h, actual %h", exp_res.pc,
                     out_program_counter);
            if (out_row_pixels !== exp_res.pixels)
              $error("row_pixels: expected %h, actual %h", exp_res.pixels, out_row_pixels);
            if (out_sound_on !== exp_res.sound)
              $error("sound_on: expected %b, actual %b", exp_res.sound, out_sound_on);
            if (out_waiting_key !== exp_res.waiting)
              $error("waiting_key: expected %b, actual %b", exp_res.waiting,
                     out_waiting_key);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(step_machine(in_func, in_address, in_data, in_key_mask,
                                          in_random_byte));
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the interpreter core with directed and random programs: loads
// instruction words into memory, executes them with random keys and random
// bytes, ticks the timers and reads screen rows, with idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import c8vm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [11:0] in_address;
  logic [7:0]  in_data;
  logic [15:0] in_key_mask;
  logic [7:0]  in_random_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_program_counter;
  logic [63:0] out_row_pixels;
  logic        out_sound_on;
  logic        out_waiting_key;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          calm;
  logic [15:0] load_ptr;

  bytecode_vm_cpu_core dut (.*);

  c8vm_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The item stays presented after acceptance until the next call or an
  // explicit drop by the caller, so valid changes only at falling edges.
  task automatic send_item(logic [1:0] fn, logic [11:0] addr, logic [7:0] dat,
      logic [15:0] keys, logic [7:0] rnd);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_address <= addr;
    in_data <= dat;
    in_key_mask <= keys;
    in_random_byte <= rnd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic random_keys(output logic [15:0] keys);
    case ($urandom_range(3))
      0: keys = '0;
      1: keys = 16'(1 << $urandom_range(15));
      default: keys = 16'($urandom);
    endcase
  endtask

  // Writes one instruction word at the load pointer and sends one execute item.
  task automatic run_op(logic [15:0] op);
    logic [15:0] keys;
    logic [15:0] at;
    at = (load_ptr >= MEM_BYTES - 1) ? PC_RESET : load_ptr;
    send_item(FN_LOAD, at[11:0], op[15:8], 16'($urandom), 8'($urandom));
    send_item(FN_LOAD, at[11:0] + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
    random_keys(keys);
    send_item(FN_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom));
  endtask

  function automatic logic [15:0] random_op();
    logic [3:0] x, y, n;
    logic [7:0] kk;
    logic [11:0] nnn;
    x = 4'($urandom);
    y = 4'($urandom);
    n = 4'($urandom_range(6));
    kk = 8'($urandom);
    nnn = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(12'h200, 12'h3FE));
    case ($urandom_range(25))
      0: return {OP_SYS, SYS_CLS};
      1, 2: return {OP_SYS, SYS_RET};
      3: return {OP_SYS, 12'($urandom)};
      4: return {OP_JP, nnn};
      5, 6: return {OP_CALL, nnn};
      7: return {OP_SE, x, kk};
      8: return {OP_SNE, x, kk};
      9: return {OP_SER, x, y, 4'($urandom_range(1) ? 0 : $urandom)};
      10: return {OP_LD, x, ($urandom_range(1) ? 8'($urandom_range(15)) : kk)};
      11: return {OP_ADD, x, kk};
      12, 13: return {OP_ALU, x, y, 4'($urandom)};
      14: return {OP_SNER, x, y, 4'($urandom_range(1) ? 0 : $urandom)};
      15: return {OP_LDI, ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(4095))};
      16: return {OP_JPV0, nnn};
      17: return {OP_RND, x, kk};
      18, 19: return {OP_DRW, x, y, ($urandom_range(4) == 0) ? 4'($urandom) : n};
      20: return {OP_SKP, x, ($urandom_range(1) ? KEY_DOWN : KEY_UP)};
      21: return {OP_SKP, x, kk};
      default: begin
        case ($urandom_range(10))
          0: return {OP_MISC, x, F_GET_DT};
          1: return {OP_MISC, x, F_WAIT_KEY};
          2: return {OP_MISC, x, F_SET_DT};
          3: return {OP_MISC, x, F_SET_ST};
          4: return {OP_MISC, x, F_ADD_I};
          5: return {OP_MISC, x, F_GLYPH};
          6: return {OP_MISC, x, F_BCD};
          7: return {OP_MISC, x, F_STORE};
          8: return {OP_MISC, x, F_LOAD};
          default: return {OP_MISC, x, kk};
        endcase
      end
    endcase
  endfunction

  initial begin
    int sent;
    logic [15:0] op;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_address = '0;
    in_data = '0;
    in_key_mask = '0;
    in_random_byte = '0;
    load_ptr = PC_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, error paths and the SYS, JP, LD, ALU, LDI, DRW and Fx groups.
    send_item(FN_ROW, 12'd0, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(FN_ROW, 12'd4095, 8'h00, 16'h0000, 8'h00);
    send_item(FN_TICK, 12'd0, 8'h00, 16'h0000, 8'h00);
    run_op({OP_MISC, 4'd0, F_WAIT_KEY});
    run_op({OP_SYS, SYS_RET});
    run_op({OP_LD, 4'd1, 8'hFF});
    run_op({OP_ALU, 4'd1, 4'd1, ALU_ADD});
    run_op({OP_MISC, 4'd1, F_GLYPH});
    run_op({OP_MISC, 4'd1, F_SET_ST});
    run_op({OP_LDI, 12'hFFF});
    run_op({OP_DRW, 4'd0, 4'd0, 4'd2});
    run_op({OP_MISC, 4'd15, F_STORE});
    run_op({OP_LDI, 12'd80});
    run_op({OP_DRW, 4'd1, 4'd1, 4'd15});
    run_op({OP_DRW, 4'd1, 4'd1, 4'd0});
    send_item(FN_ROW, 12'd31, 8'h00, 16'h0000, 8'h00);
    send_item(FN_LOAD, 12'd4095, 8'hAA, 16'h0000, 8'h00);
    run_op({OP_JP, 12'hFFE});
    load_ptr = PC_RESET;
    send_item(FN_EXEC, 12'd0, 8'h00, 16'h8000, 8'h00);
    run_op({OP_JP, 12'h200});

    // Random programs: mostly instructions at the program counter.
    sent = 0;
    while (sent < 1950) begin
      calm = (sent >= 700 && sent < 950);
      load_ptr = out_program_counter;
      case ($urandom_range(19))
        0: begin send_item(FN_TICK, 12'($urandom), 8'($urandom), 16'($urandom),
                           8'($urandom)); sent++; end
        1: begin send_item(FN_ROW, ($urandom_range(7) == 0) ? 12'($urandom) :
                           12'($urandom_range(31)), 8'($urandom), 16'($urandom),
                           8'($urandom)); sent++; end
        2: begin send_item(FN_LOAD, 12'($urandom), 8'($urandom), 16'($urandom),
                           8'($urandom)); sent++; end
        default: begin
          in_valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
          load_ptr = out_program_counter;
          op = random_op();
          run_op(op);
          sent += 3;
        end
      endcase
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
